FILE: rtl/hbch_pkg.sv
package hbch_pkg;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_FRAME = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [1:0] CFG_BOX_W   = 2'd0;
  localparam logic [1:0] CFG_BOX_H   = 2'd1;
  localparam logic [1:0] CFG_MIN_D   = 2'd2;
  localparam logic [1:0] CFG_BIN_W   = 2'd3;

  localparam int DIV_W = 48;
  localparam logic [5:0] DIV_BITS_NARROW = 6'd24;
  localparam logic [5:0] DIV_BITS_WIDE   = 6'd48;

  // 1/K of the rotation pass in Q2.30
  localparam logic [31:0] CORDIC_INIT = 32'h26DD3B6A;

  typedef struct packed {
    logic       start;
    logic [5:0] nbits;
  } div_req_t;

  typedef struct packed {
    logic [23:0]        mx;
    logic [23:0]        my;
    logic signed [15:0] cr;
    logic signed [15:0] ci;
  } bond_t;

  typedef struct packed {
    logic signed [47:0] sr;
    logic signed [47:0] si;
    logic [31:0]        cnt;
  } hist_t;

  // binary angles of atan(2^-i), one turn = 2^32
  function automatic logic [31:0] angle_step(input logic [4:0] idx);
    logic [31:0] a;
    case (idx)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2F9;
      5'd15: a = 32'h0000517C;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A2F;
      5'd19: a = 32'h00000517;
      5'd20: a = 32'h0000028B;
      5'd21: a = 32'h00000145;
      5'd22: a = 32'h000000A2;
      5'd23: a = 32'h00000051;
      default: a = 32'h0;
    endcase
    return a;
  endfunction

endpackage

FILE: rtl/hbch_div.sv
module hbch_div (
  input  logic                 clk,
  input  logic                 rst,
  input  hbch_pkg::div_req_t   req,
  input  logic [47:0]          dividend,
  input  logic [47:0]          divisor,
  output logic                 done,
  output logic [47:0]          quotient,
  output logic [47:0]          remainder
);

  logic [47:0] num;
  logic [47:0] den;
  logic [47:0] rem;
  logic [47:0] quo;
  logic [5:0]  idx;
  logic        busy;
  logic [48:0] shifted;
  logic        ge;
  logic [48:0] diff;

  // restoring division, one quotient bit per cycle
  always_comb begin
    shifted = {rem, num[idx]};
    ge      = shifted >= {1'b0, den};
    diff    = shifted - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        num  <= dividend;
        den  <= divisor;
        rem  <= '0;
        quo  <= '0;
        idx  <= req.nbits - 6'd1;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? diff[47:0] : shifted[47:0];
        quo <= {quo[46:0], ge};
        idx <= idx - 6'd1;
        if (idx == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

FILE: rtl/hbch_isqrt.sv
module hbch_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [47:0] value,
  output logic        done,
  output logic [23:0] root
);

  logic [47:0] v;
  logic [47:0] res;
  logic [47:0] one;
  logic [4:0]  cnt;
  logic        busy;
  logic [47:0] trial;

  assign trial = res + one;

  // two radicand bits per step, 24 steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        v    <= value;
        res  <= '0;
        one  <= 48'h4000_0000_0000;
        cnt  <= 5'd23;
        busy <= 1'b1;
      end else if (busy) begin
        if (v >= trial) begin
          v   <= v - trial;
          res <= (res >> 1) + one;
        end else begin
          res <= res >> 1;
        end
        one <= one >> 2;
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign root = res[23:0];

endmodule

FILE: rtl/hbch_cordic.sv
module hbch_cordic #(
  parameter int STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [25:0] dx,
  input  logic signed [25:0] dy,
  output logic               done,
  output logic signed [15:0] cos_q,
  output logic signed [15:0] sin_q
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_VEC  = 2'd1;
  localparam logic [1:0] PH_SET  = 2'd2;
  localparam logic [1:0] PH_ROT  = 2'd3;

  logic [1:0]         phase;
  logic signed [33:0] x;
  logic signed [33:0] y;
  logic signed [33:0] xs;
  logic signed [33:0] ys;
  logic signed [33:0] x_n;
  logic signed [33:0] y_n;
  logic signed [33:0] xf;
  logic signed [33:0] yf;
  logic signed [33:0] x0;
  logic signed [33:0] y0;
  logic [31:0]        ang;
  logic [31:0]        ang_n;
  logic [31:0]        a;
  logic [31:0]        th6;
  logic               flip;
  logic [4:0]         i;
  logic               pos;

  function automatic logic signed [15:0] to_q15(input logic signed [33:0] v);
    logic signed [34:0] r;
    r = ($signed({v[33], v}) + 35'sd16384) >>> 15;
    if (r > 35'sd32767) return 16'sh7FFF;
    else if (r < -35'sd32768) return 16'sh8000;
    else return r[15:0];
  endfunction

  // one add/sub/shift datapath serves both the vectoring and the rotation pass
  always_comb begin
    xs    = x >>> i;
    ys    = y >>> i;
    a     = hbch_pkg::angle_step(i);
    pos   = (phase == PH_VEC) ? y[33] : !ang[31];
    x_n   = pos ? x - ys : x + ys;
    y_n   = pos ? y + xs : y - xs;
    ang_n = pos ? ang - a : ang + a;
    th6   = {ang[29:0], 2'b00} + {ang[30:0], 1'b0};
    x0    = {{2{dx[25]}}, dx, 6'b0};
    y0    = {{2{dy[25]}}, dy, 6'b0};
    xf    = flip ? -x_n : x_n;
    yf    = flip ? -y_n : y_n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        PH_IDLE: begin
          if (start) begin
            i <= '0;
            if (dx == 26'sd0 && dy == 26'sd0) begin
              ang   <= '0;
              phase <= PH_SET;
            end else begin
              phase <= PH_VEC;
              if (x0 < 34'sd0) begin
                x   <= -x0;
                y   <= -y0;
                ang <= 32'h8000_0000;
              end else begin
                x   <= x0;
                y   <= y0;
                ang <= '0;
              end
            end
          end
        end
        PH_VEC: begin
          x   <= x_n;
          y   <= y_n;
          ang <= ang_n;
          if (i == 5'(STEPS - 1)) phase <= PH_SET;
          else i <= i + 5'd1;
        end
        PH_SET: begin
          // fold the second and third quadrant by a half turn
          if (th6[31] ^ th6[30]) begin
            ang  <= {~th6[31], th6[30:0]};
            flip <= 1'b1;
          end else begin
            ang  <= th6;
            flip <= 1'b0;
          end
          x     <= {2'b00, hbch_pkg::CORDIC_INIT};
          y     <= '0;
          i     <= '0;
          phase <= PH_ROT;
        end
        PH_ROT: begin
          x   <= x_n;
          y   <= y_n;
          ang <= ang_n;
          if (i == 5'(STEPS - 1)) begin
            cos_q <= to_q15(xf);
            sin_q <= to_q15(yf);
            done  <= 1'b1;
            phase <= PH_IDLE;
          end else begin
            i <= i + 5'd1;
          end
        end
        default: phase <= PH_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/hexatic_bond_correlation_histogram_core.sv
// Bond-orientational (g6) correlation histogram. A load item stores one bond's midpoint and
// its sixfold order pair, using two serial 24-step remainders for the periodic midpoint,
// with the CORDIC running alongside. An end-frame item walks all n*(n+1)/2 bond pairs;
// each pair runs the 24-step square root and then, unless the distance is below min_dist,
// the 24-step bin division. A readout item emits min(NUM_BINS,64) results, each using two
// 48-step divisions for the means (an empty bin needs none), then clears any bins beyond
// 64 at one a cycle. After reset the histogram is cleared before the first item is taken.
// Only one item is in work at a time: item_stall stays high until it is finished and, for a
// readout, until its last result is taken.
module hexatic_bond_correlation_histogram_core #(
  parameter int MAX_BONDS    = 256,
  parameter int NUM_BINS     = 64,
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [1:0]         command,
  input  logic [23:0]        first_x,
  input  logic [23:0]        first_y,
  input  logic [23:0]        second_x,
  input  logic [23:0]        second_y,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [5:0]         bin_index,
  output logic signed [15:0] mean_real,
  output logic signed [15:0] mean_imag,
  output logic [31:0]        pair_total,
  output logic               dropped_flag,
  output logic               last_bin,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  localparam int AW   = $clog2(MAX_BONDS);
  localparam int CW   = $clog2(MAX_BONDS + 1);
  localparam int BW   = $clog2(NUM_BINS);
  localparam int NOUT = (NUM_BINS < 64) ? NUM_BINS : 64;

  localparam logic [4:0] S_CLR      = 5'd0;
  localparam logic [4:0] S_IDLE     = 5'd1;
  localparam logic [4:0] S_LD_DIFF  = 5'd2;
  localparam logic [4:0] S_LD_START = 5'd3;
  localparam logic [4:0] S_LD_WX    = 5'd4;
  localparam logic [4:0] S_LD_WY    = 5'd5;
  localparam logic [4:0] S_LD_WC    = 5'd6;
  localparam logic [4:0] S_FR_RDI   = 5'd7;
  localparam logic [4:0] S_FR_LATI  = 5'd8;
  localparam logic [4:0] S_FR_RDJ   = 5'd9;
  localparam logic [4:0] S_FR_DIFF  = 5'd10;
  localparam logic [4:0] S_FR_SQX   = 5'd11;
  localparam logic [4:0] S_FR_SQY   = 5'd12;
  localparam logic [4:0] S_FR_P1    = 5'd13;
  localparam logic [4:0] S_FR_P2    = 5'd14;
  localparam logic [4:0] S_FR_P3    = 5'd15;
  localparam logic [4:0] S_FR_P4    = 5'd16;
  localparam logic [4:0] S_FR_WSQ   = 5'd17;
  localparam logic [4:0] S_FR_WDIV  = 5'd18;
  localparam logic [4:0] S_FR_HRD   = 5'd19;
  localparam logic [4:0] S_FR_HWR   = 5'd20;
  localparam logic [4:0] S_FR_NEXT  = 5'd21;
  localparam logic [4:0] S_RO_HRD   = 5'd22;
  localparam logic [4:0] S_RO_LAT   = 5'd23;
  localparam logic [4:0] S_RO_DR    = 5'd24;
  localparam logic [4:0] S_RO_DI    = 5'd25;
  localparam logic [4:0] S_RO_OUT   = 5'd26;

  logic [4:0]  st;
  logic [11:0] box_w;
  logic [11:0] box_h;
  logic [23:0] min_dist;
  logic [23:0] bin_w;
  logic [12:0] reg_x;
  logic [12:0] reg_y;
  logic [24:0] len_x;
  logic [24:0] len_y;
  logic [23:0] bw_eff;

  logic [23:0] in_x1;
  logic [23:0] in_y1;
  logic [23:0] in_x2;
  logic [23:0] in_y2;
  logic signed [25:0] dx_r;
  logic signed [25:0] dy_r;
  logic signed [27:0] t_x;
  logic signed [27:0] t_y;
  logic signed [24:0] hs_x;
  logic signed [24:0] hs_y;
  logic [23:0] hy;
  logic [11:0] lowx;
  logic [11:0] lowy;
  logic [23:0] mid_x;
  logic [23:0] mid_y;
  logic        cord_seen;

  logic [CW-1:0] count;
  logic          drop;
  logic [AW-1:0] i;
  logic [AW-1:0] j;
  logic [AW-1:0] bond_ra;
  logic          bond_we;
  hbch_pkg::bond_t bond_wd;
  hbch_pkg::bond_t bond_q;
  hbch_pkg::bond_t bi;
  hbch_pkg::bond_t bond_mem [MAX_BONDS];

  logic signed [25:0] ddx;
  logic signed [25:0] ddy;
  logic signed [25:0] mul_a;
  logic signed [25:0] mul_b;
  logic signed [51:0] prod;
  logic signed [51:0] acc;
  logic signed [51:0] sq_sum;
  logic signed [51:0] re_sum;
  logic signed [51:0] im_sum;
  logic signed [32:0] re;
  logic signed [32:0] im;

  logic [BW-1:0]   hk;
  logic [BW-1:0]   k;
  logic [BW-1:0]   clr;
  logic [BW-1:0]   hw_addr;
  logic            hw_en;
  hbch_pkg::hist_t hw_data;
  hbch_pkg::hist_t upd;
  hbch_pkg::hist_t hist_q;
  hbch_pkg::hist_t ent;
  hbch_pkg::hist_t hist_mem [NUM_BINS];

  hbch_pkg::div_req_t div_req;
  logic [47:0] div_dividend;
  logic [47:0] div_divisor;
  logic        div_done;
  logic [47:0] div_quo;
  logic [47:0] div_rem;

  logic        sqrt_start;
  logic        sqrt_done;
  logic [23:0] root;

  logic               cord_start;
  logic               cord_done;
  logic signed [15:0] cord_c;
  logic signed [15:0] cord_s;

  function automatic logic signed [25:0] wrap_diff(input logic [24:0] len,
                                                   input logic [23:0] a,
                                                   input logic [23:0] b);
    logic signed [26:0] d;
    logic signed [26:0] mag;
    logic signed [26:0] other;
    logic signed [26:0] nother;
    d      = $signed({3'b000, a}) - $signed({3'b000, b});
    mag    = d[26] ? -d : d;
    other  = $signed({2'b00, len}) - mag;
    nother = -other;
    if (other > mag) return d[25:0];
    else if (d > 27'sd0) return nother[25:0];
    else if (d < 27'sd0) return other[25:0];
    else return 26'sd0;
  endfunction

  function automatic logic signed [47:0] sat_add(input logic signed [47:0] s,
                                                 input logic signed [32:0] p);
    logic signed [48:0] t;
    t = {s[47], s} + {{16{p[32]}}, p};
    if (t[48] != t[47]) return t[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
    else return t[47:0];
  endfunction

  // rounding offset is half the divisor, so ties go away from zero
  function automatic logic [47:0] mean_num(input logic signed [47:0] s,
                                           input logic [31:0] c);
    logic [47:0] mag;
    mag = s[47] ? 48'(-s) : 48'(s);
    return mag + {2'b00, c, 14'b0};
  endfunction

  function automatic logic [15:0] mean_sat(input logic [47:0] q, input logic neg);
    logic [16:0] nq;
    nq = -q[16:0];
    if (neg) return (q > 48'd32768) ? 16'h8000 : nq[15:0];
    else return (q > 48'd32767) ? 16'h7FFF : q[15:0];
  endfunction

  always_comb begin
    reg_x  = (box_w == 12'd0) ? 13'd4096 : {1'b0, box_w};
    reg_y  = (box_h == 12'd0) ? 13'd4096 : {1'b0, box_h};
    len_x  = {reg_x, 12'b0};
    len_y  = {reg_y, 12'b0};
    bw_eff = (bin_w == 24'd0) ? 24'd1 : bin_w;
  end

  // midpoint: (2*x1 - dx) >> 1, split into whole units and a 12-bit fraction;
  // a multiple of the box length keeps the remainder input non-negative
  always_comb begin
    t_x  = $signed({3'b000, in_x1, 1'b0}) - $signed({{2{dx_r[25]}}, dx_r});
    t_y  = $signed({3'b000, in_y1, 1'b0}) - $signed({{2{dy_r[25]}}, dy_r});
    hs_x = $signed(t_x[27:13]) + $signed({1'b0, reg_x, 11'b0});
    hs_y = $signed(t_y[27:13]) + $signed({1'b0, reg_y, 11'b0});
  end

  // shared multiplier
  always_comb begin
    case (st)
      S_FR_SQY: begin mul_a = ddy; mul_b = ddy; end
      S_FR_P1:  begin mul_a = 26'(bi.cr); mul_b = 26'(bond_q.cr); end
      S_FR_P2:  begin mul_a = 26'(bi.ci); mul_b = 26'(bond_q.ci); end
      S_FR_P3:  begin mul_a = 26'(bond_q.cr); mul_b = 26'(bi.ci); end
      S_FR_P4:  begin mul_a = 26'(bi.cr); mul_b = 26'(bond_q.ci); end
      default:  begin mul_a = ddx; mul_b = ddx; end
    endcase
    prod   = mul_a * mul_b;
    sq_sum = acc + prod;
    re_sum = acc + prod;
    im_sum = acc - prod;
  end

  always_comb begin
    div_req.start = 1'b0;
    div_req.nbits = hbch_pkg::DIV_BITS_NARROW;
    div_dividend  = '0;
    div_divisor   = '0;
    case (st)
      S_LD_START: begin
        div_req.start = 1'b1;
        div_dividend  = {24'b0, hs_x[23:0]};
        div_divisor   = {35'b0, reg_x};
      end
      S_LD_WX: begin
        div_req.start = div_done;
        div_dividend  = {24'b0, hy};
        div_divisor   = {35'b0, reg_y};
      end
      S_FR_WSQ: begin
        div_req.start = sqrt_done && (root >= min_dist);
        div_dividend  = {24'b0, root - min_dist};
        div_divisor   = {24'b0, bw_eff};
      end
      S_RO_LAT: begin
        div_req.start = hist_q.cnt != 32'd0;
        div_req.nbits = hbch_pkg::DIV_BITS_WIDE;
        div_dividend  = mean_num(hist_q.sr, hist_q.cnt);
        div_divisor   = {1'b0, hist_q.cnt, 15'b0};
      end
      S_RO_DR: begin
        div_req.start = div_done;
        div_req.nbits = hbch_pkg::DIV_BITS_WIDE;
        div_dividend  = mean_num(ent.si, ent.cnt);
        div_divisor   = {1'b0, ent.cnt, 15'b0};
      end
      default: ;
    endcase
  end

  assign sqrt_start = (st == S_FR_SQY);
  assign cord_start = (st == S_LD_START);

  hbch_div u_div (
    .clk       (clk),
    .rst       (rst),
    .req       (div_req),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  hbch_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .value (sq_sum[47:0]),
    .done  (sqrt_done),
    .root  (root)
  );

  hbch_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cord_start),
    .dx    (dx_r),
    .dy    (dy_r),
    .done  (cord_done),
    .cos_q (cord_c),
    .sin_q (cord_s)
  );

  // bond store
  always_comb begin
    bond_ra    = (st == S_FR_RDI) ? i : j;
    bond_we    = (st == S_LD_WC) && cord_seen;
    bond_wd.mx = mid_x;
    bond_wd.my = mid_y;
    bond_wd.cr = cord_c;
    bond_wd.ci = cord_s;
  end

  always_ff @(posedge clk) begin
    if (bond_we) bond_mem[count[AW-1:0]] <= bond_wd;
    bond_q <= bond_mem[bond_ra];
  end

  // histogram store
  always_comb begin
    upd.sr  = sat_add(hist_q.sr, re);
    upd.si  = sat_add(hist_q.si, im);
    upd.cnt = (hist_q.cnt == 32'hFFFF_FFFF) ? hist_q.cnt : hist_q.cnt + 32'd1;
    hw_en   = (st == S_CLR) || (st == S_FR_HWR) || (st == S_RO_OUT && !result_stall);
    hw_addr = (st == S_CLR) ? clr : hk;
    hw_data = (st == S_FR_HWR) ? upd : '0;
  end

  always_ff @(posedge clk) begin
    if (hw_en) hist_mem[hw_addr] <= hw_data;
    hist_q <= hist_mem[hk];
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      box_w    <= 12'd256;
      box_h    <= 12'd256;
      min_dist <= 24'd0;
      bin_w    <= 24'd4096;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        hbch_pkg::CFG_BOX_W: box_w    <= cfg_data[11:0];
        hbch_pkg::CFG_BOX_H: box_h    <= cfg_data[11:0];
        hbch_pkg::CFG_MIN_D: min_dist <= cfg_data;
        hbch_pkg::CFG_BIN_W: bin_w    <= cfg_data;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_CLR;
      clr       <= '0;
      count     <= '0;
      drop      <= 1'b0;
      cord_seen <= 1'b0;
      hk        <= '0;
      k         <= '0;
    end else begin
      if (cord_done) cord_seen <= 1'b1;
      unique case (st)
        S_CLR: begin
          if (clr == BW'(NUM_BINS - 1)) st <= S_IDLE;
          else clr <= clr + 1'b1;
        end
        S_IDLE: begin
          if (item_valid) begin
            unique case (command)
              hbch_pkg::CMD_LOAD: begin
                if (count >= CW'(MAX_BONDS)) begin
                  drop <= 1'b1;
                end else begin
                  in_x1 <= first_x;
                  in_y1 <= first_y;
                  in_x2 <= second_x;
                  in_y2 <= second_y;
                  st    <= S_LD_DIFF;
                end
              end
              hbch_pkg::CMD_FRAME: begin
                if (count != '0) begin
                  i  <= '0;
                  j  <= '0;
                  st <= S_FR_RDI;
                end
              end
              hbch_pkg::CMD_READ: begin
                k  <= '0;
                hk <= '0;
                st <= S_RO_HRD;
              end
              default: ;
            endcase
          end
        end
        S_LD_DIFF: begin
          dx_r <= wrap_diff(len_x, in_x1, in_x2);
          dy_r <= wrap_diff(len_y, in_y1, in_y2);
          st   <= S_LD_START;
        end
        S_LD_START: begin
          hy        <= hs_y[23:0];
          lowx      <= t_x[12:1];
          lowy      <= t_y[12:1];
          cord_seen <= 1'b0;
          st        <= S_LD_WX;
        end
        S_LD_WX: begin
          if (div_done) begin
            mid_x <= {div_rem[11:0], lowx};
            st    <= S_LD_WY;
          end
        end
        S_LD_WY: begin
          if (div_done) begin
            mid_y <= {div_rem[11:0], lowy};
            st    <= S_LD_WC;
          end
        end
        S_LD_WC: begin
          if (cord_seen) begin
            count <= count + 1'b1;
            st    <= S_IDLE;
          end
        end
        S_FR_RDI: st <= S_FR_LATI;
        S_FR_LATI: begin
          bi <= bond_q;
          st <= S_FR_DIFF;
        end
        S_FR_RDJ: st <= S_FR_DIFF;
        S_FR_DIFF: begin
          ddx <= wrap_diff(len_x, bi.mx, bond_q.mx);
          ddy <= wrap_diff(len_y, bi.my, bond_q.my);
          st  <= S_FR_SQX;
        end
        S_FR_SQX: begin
          acc <= prod;
          st  <= S_FR_SQY;
        end
        S_FR_SQY: st <= S_FR_P1;
        S_FR_P1: begin
          acc <= prod;
          st  <= S_FR_P2;
        end
        S_FR_P2: begin
          re <= re_sum[32:0];
          st <= S_FR_P3;
        end
        S_FR_P3: begin
          acc <= prod;
          st  <= S_FR_P4;
        end
        S_FR_P4: begin
          im <= im_sum[32:0];
          st <= S_FR_WSQ;
        end
        S_FR_WSQ: begin
          if (sqrt_done) begin
            if (root < min_dist) begin
              drop <= 1'b1;
              st   <= S_FR_NEXT;
            end else begin
              st <= S_FR_WDIV;
            end
          end
        end
        S_FR_WDIV: begin
          if (div_done) begin
            if (div_quo >= 48'(NUM_BINS)) begin
              drop <= 1'b1;
              st   <= S_FR_NEXT;
            end else begin
              hk <= div_quo[BW-1:0];
              st <= S_FR_HRD;
            end
          end
        end
        S_FR_HRD: st <= S_FR_HWR;
        S_FR_HWR: st <= S_FR_NEXT;
        S_FR_NEXT: begin
          if (j == i) begin
            if (CW'(i) + 1'b1 == count) begin
              count <= '0;
              st    <= S_IDLE;
            end else begin
              i  <= i + 1'b1;
              j  <= '0;
              st <= S_FR_RDI;
            end
          end else begin
            j  <= j + 1'b1;
            st <= S_FR_RDJ;
          end
        end
        S_RO_HRD: st <= S_RO_LAT;
        S_RO_LAT: begin
          ent        <= hist_q;
          pair_total <= hist_q.cnt;
          if (hist_q.cnt == 32'd0) begin
            mean_real <= '0;
            mean_imag <= '0;
            st        <= S_RO_OUT;
          end else begin
            st <= S_RO_DR;
          end
        end
        S_RO_DR: begin
          if (div_done) begin
            mean_real <= mean_sat(div_quo, ent.sr[47]);
            st        <= S_RO_DI;
          end
        end
        S_RO_DI: begin
          if (div_done) begin
            mean_imag <= mean_sat(div_quo, ent.si[47]);
            st        <= S_RO_OUT;
          end
        end
        S_RO_OUT: begin
          if (!result_stall) begin
            if (k == BW'(NOUT - 1)) begin
              if (NUM_BINS > NOUT) begin
                clr <= BW'(NOUT);
                st  <= S_CLR;
              end else begin
                st <= S_IDLE;
              end
            end else begin
              k  <= k + 1'b1;
              hk <= hk + 1'b1;
              st <= S_RO_HRD;
            end
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  assign item_stall   = (st != S_IDLE);
  assign result_valid = (st == S_RO_OUT);
  assign bin_index    = 6'(k);
  assign dropped_flag = drop;
  assign last_bin     = (k == BW'(NOUT - 1));

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_BONDS))
    else $error("bond count past capacity");

  a_drop_sticky: assert property (@(posedge clk) disable iff (rst)
    drop |=> drop)
    else $error("drop flag cleared without reset");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && last_bin |=> !result_valid)
    else $error("result after final bin");

  a_read_blocks: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && command == hbch_pkg::CMD_READ |=> item_stall)
    else $error("input taken during readout");

endmodule

FILE: test/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam longint CYCLE_LIMIT = 64'd12000000;
  localparam int HOLD_CYCLES = 3000;
  localparam int SETTLE_CYCLES = 300;
  localparam longint SUM_HI = 64'sh7FFFFFFFFFFF;
  localparam longint SUM_LO = -64'sh7FFFFFFFFFFF - 1;
  localparam int BOND_CAP = 256;
  localparam int BIN_CNT = 64;

  typedef struct {
    logic [1:0]  cmd;
    logic [23:0] fx, fy, sx, sy;
  } bond_item_t;

  typedef struct {
    logic [5:0]  idx;
    logic [15:0] mr, mi;
    logic [31:0] tot;
    logic        df, lb;
  } bin_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  logic [1:0] command = '0;
  logic [23:0] first_x = '0, first_y = '0, second_x = '0, second_y = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic [5:0] bin_index;
  logic signed [15:0] mean_real, mean_imag;
  logic [31:0] pair_total;
  logic dropped_flag, last_bin;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;

  hexatic_bond_correlation_histogram_core u_top (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  // predictor state
  logic [11:0] box_w_reg, box_h_reg;
  logic [23:0] min_d_reg, bin_w_reg;
  longint mid_x[BOND_CAP], mid_y[BOND_CAP], ord_c[BOND_CAP], ord_s[BOND_CAP];
  int n_bonds;
  longint hist_sr[BIN_CNT], hist_si[BIN_CNT];
  longint unsigned hist_cnt[BIN_CNT];
  bit drop_seen_m;

  bond_item_t pending[$];
  bin_report_t bins_due[$];
  int mismatches = 0;
  longint cycles = 0;

  localparam logic [31:0] ATAN_TAB [16] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C};

  function automatic longint period_len(logic [11:0] r);
    return (r == 0) ? 64'd4096 * 4096 : longint'(r) * 4096;
  endfunction

  function automatic longint min_image(longint len, longint a, longint b);
    longint d, mag, other;
    d = a - b;
    mag = (d < 0) ? -d : d;
    other = len - mag;
    if (other > mag) return d;
    if (d > 0) return -other;
    if (d < 0) return other;
    return 0;
  endfunction

  function automatic longint wrap_into(longint v, longint len);
    longint r;
    r = v % len;
    return (r < 0) ? r + len : r;
  endfunction

  function automatic longint round_q15(longint v);
    longint r;
    r = (v + 16384) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r;
  endfunction

  // sixfold order of a bond: vectoring pass for the angle, rotation pass for cos/sin
  task automatic hexatic_order(input longint dx, input longint dy,
                               output longint c, output longint s);
    logic [31:0] z, th;
    longint x, y, nx, zz;
    bit flip;
    z = 0;
    flip = 0;
    x = dx * 64;
    y = dy * 64;
    if (dx != 0 || dy != 0) begin
      if (x < 0) begin
        x = -x; y = -y; z = 32'h80000000;
      end
      for (int i = 0; i < 16; i++) begin
        if (y >= 0) begin
          nx = x + (y >>> i); y = y - (x >>> i); z = z + ATAN_TAB[i];
        end else begin
          nx = x - (y >>> i); y = y + (x >>> i); z = z - ATAN_TAB[i];
        end
        x = nx;
      end
    end
    th = z * 32'd6;
    if (th[31:30] == 2'b01 || th[31:30] == 2'b10) begin
      th = th + 32'h80000000;
      flip = 1;
    end
    zz = longint'($signed(th));
    x = 64'h26DD3B6A;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      if (zz >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); zz = zz - ATAN_TAB[i];
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); zz = zz + ATAN_TAB[i];
      end
      x = nx;
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = round_q15(x);
    s = round_q15(y);
  endtask

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, one;
    res = 0;
    one = 64'd1 << 62;
    while (one > v) one = one >> 2;
    while (one != 0) begin
      if (v >= res + one) begin
        v = v - (res + one);
        res = (res >> 1) + one;
      end else begin
        res = res >> 1;
      end
      one = one >> 2;
    end
    return res;
  endfunction

  function automatic longint clamp_sum(longint a, longint b);
    longint r;
    r = a + b;
    if (r > SUM_HI) return SUM_HI;
    if (r < SUM_LO) return SUM_LO;
    return r;
  endfunction

  function automatic logic [15:0] bin_mean(longint sum, longint unsigned cnt);
    longint unsigned den, mag, q;
    if (cnt == 0) return 16'd0;
    den = cnt << 15;
    mag = (sum < 0) ? -sum : sum;
    q = (mag + (den >> 1)) / den;
    if (sum < 0) return (q > 32768) ? 16'h8000 : 16'(-longint'(q));
    return (q > 32767) ? 16'h7FFF : 16'(q);
  endfunction

  task automatic store_bond(bond_item_t it);
    longint lx, ly, dx, dy, c, s;
    lx = period_len(box_w_reg);
    ly = period_len(box_h_reg);
    if (n_bonds >= BOND_CAP) begin
      drop_seen_m = 1;
      return;
    end
    dx = min_image(lx, it.fx, it.sx);
    dy = min_image(ly, it.fy, it.sy);
    mid_x[n_bonds] = wrap_into((2 * longint'(it.fx) - dx) >>> 1, lx);
    mid_y[n_bonds] = wrap_into((2 * longint'(it.fy) - dy) >>> 1, ly);
    hexatic_order(dx, dy, c, s);
    ord_c[n_bonds] = c;
    ord_s[n_bonds] = s;
    n_bonds++;
  endtask

  task automatic correlate_frame();
    longint lx, ly, dx, dy;
    longint unsigned dr, bw, k;
    lx = period_len(box_w_reg);
    ly = period_len(box_h_reg);
    bw = (bin_w_reg == 0) ? 1 : bin_w_reg;
    for (int i = 0; i < n_bonds; i++) begin
      for (int j = 0; j <= i; j++) begin
        dx = min_image(lx, mid_x[i], mid_x[j]);
        dy = min_image(ly, mid_y[i], mid_y[j]);
        dr = int_sqrt(longint'(dx * dx) + longint'(dy * dy));
        if (dr < min_d_reg) begin
          drop_seen_m = 1;
          continue;
        end
        k = (dr - min_d_reg) / bw;
        if (k >= BIN_CNT) begin
          drop_seen_m = 1;
          continue;
        end
        hist_sr[k] = clamp_sum(hist_sr[k], ord_c[i] * ord_c[j] + ord_s[i] * ord_s[j]);
        hist_si[k] = clamp_sum(hist_si[k], ord_c[j] * ord_s[i] - ord_c[i] * ord_s[j]);
        if (hist_cnt[k] != 64'hFFFFFFFF) hist_cnt[k]++;
      end
    end
    n_bonds = 0;
  endtask

  task automatic queue_readout();
    bin_report_t r;
    for (int k = 0; k < BIN_CNT; k++) begin
      r.idx = k[5:0];
      r.mr = bin_mean(hist_sr[k], hist_cnt[k]);
      r.mi = bin_mean(hist_si[k], hist_cnt[k]);
      r.tot = hist_cnt[k][31:0];
      r.df = drop_seen_m;
      r.lb = (k == BIN_CNT - 1);
      bins_due.push_back(r);
    end
    for (int k = 0; k < BIN_CNT; k++) begin
      hist_sr[k] = 0; hist_si[k] = 0; hist_cnt[k] = 0;
    end
  endtask

  task automatic predict_item(bond_item_t it);
    case (it.cmd)
      hbch_pkg::CMD_LOAD:  store_bond(it);
      hbch_pkg::CMD_FRAME: correlate_frame();
      hbch_pkg::CMD_READ:  queue_readout();
      default: ;
    endcase
  endtask

  // sender: bursts of random length with random gaps
  int burst_left = 0, gap_left = 0;
  bond_item_t on_bus;
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) predict_item(on_bus);
      if (!item_valid || !item_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          item_valid <= 1'b0;
        end else if (pending.size() > 0) begin
          on_bus = pending.pop_front();
          command <= on_bus.cmd;
          first_x <= on_bus.fx;
          first_y <= on_bus.fy;
          second_x <= on_bus.sx;
          second_y <= on_bus.sy;
          item_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 10);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern with occasional mode changes, one long hold-off
  int stall_mode = 0, mode_left = 0, hold_left = 0;
  bit hold_done = 0;
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else if (!hold_done && result_valid && item_valid) begin
      hold_done = 1;
      hold_left = HOLD_CYCLES;
      result_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: result_stall <= 1'b0;
        1: result_stall <= ($urandom_range(0, 3) == 0);
        default: result_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // result checker
  always @(posedge clk) begin
    bin_report_t want;
    if (!rst && result_valid && !result_stall) begin
      if (bins_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected bin report: bin %0d", bin_index);
      end else begin
        want = bins_due.pop_front();
        if (bin_index !== want.idx || mean_real !== want.mr || mean_imag !== want.mi ||
            pair_total !== want.tot || dropped_flag !== want.df || last_bin !== want.lb) begin
          mismatches++;
          if (mismatches <= 10)
            $display("bin mismatch: exp %0d %h %h %0d %b %b, got %0d %h %h %0d %b %b",
                     want.idx, want.mr, want.mi, want.tot, want.df, want.lb, bin_index,
                     mean_real, mean_imag, pair_total, dropped_flag, last_bin);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic push_item(logic [1:0] cmd, logic [23:0] fx, logic [23:0] fy,
                           logic [23:0] sx, logic [23:0] sy);
    bond_item_t it;
    it.cmd = cmd; it.fx = fx; it.fy = fy; it.sx = sx; it.sy = sy;
    pending.push_back(it);
  endtask

  // mostly short bonds near a random spot, sometimes arbitrary endpoints
  task automatic push_random_bond(logic [11:0] span_x, logic [11:0] span_y);
    logic [23:0] fx, fy;
    if ($urandom_range(0, 4) == 0) begin
      push_item(hbch_pkg::CMD_LOAD, 24'($urandom), 24'($urandom), 24'($urandom),
                24'($urandom));
    end else begin
      fx = 24'($urandom_range(0, ((span_x == 0) ? 4096 : span_x) * 4096 - 1));
      fy = 24'($urandom_range(0, ((span_y == 0) ? 4096 : span_y) * 4096 - 1));
      push_item(hbch_pkg::CMD_LOAD, fx, fy, 24'(fx + $urandom_range(0, 65535) - 32768),
                24'(fy + $urandom_range(0, 65535) - 32768));
    end
  endtask

  task automatic wait_idle();
    while (pending.size() > 0 || item_valid || bins_due.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      hbch_pkg::CFG_BOX_W: box_w_reg = val[11:0];
      hbch_pkg::CFG_BOX_H: box_h_reg = val[11:0];
      hbch_pkg::CFG_MIN_D: min_d_reg = val;
      default:             bin_w_reg = val;
    endcase
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [23:0] pick_value(logic [23:0] lo_v, logic [23:0] hi_v,
                                             logic [23:0] rnd);
    case ($urandom_range(0, 4))
      0: return lo_v;
      1: return hi_v;
      default: return rnd;
    endcase
  endfunction

  initial begin
    logic [11:0] bw_now, bh_now;
    int nb;
    box_w_reg = 256; box_h_reg = 256; min_d_reg = 0; bin_w_reg = 4096;
    n_bonds = 0;
    drop_seen_m = 0;
    for (int k = 0; k < BIN_CNT; k++) begin
      hist_sr[k] = 0; hist_si[k] = 0; hist_cnt[k] = 0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: empty readout, zero-length and extreme bonds, unused command
    push_item(hbch_pkg::CMD_READ, 0, 0, 0, 0);
    push_item(hbch_pkg::CMD_FRAME, 0, 0, 0, 0);
    push_item(hbch_pkg::CMD_LOAD, 24'h010000, 24'h010000, 24'h010000, 24'h010000);
    push_item(hbch_pkg::CMD_LOAD, 24'hFFFFFF, 24'hFFFFFF, 24'h000000, 24'h000000);
    push_item(hbch_pkg::CMD_LOAD, 24'h000000, 24'h000000, 24'hFFFFFF, 24'hFFFFFF);
    push_item(hbch_pkg::CMD_LOAD, 24'h012000, 24'h020000, 24'h010000, 24'h020000);
    push_item(hbch_pkg::CMD_LOAD, 24'h010000, 24'h020000, 24'h012000, 24'h020000);
    push_item(hbch_pkg::CMD_LOAD, 24'h030000, 24'h031000, 24'h030000, 24'h030000);
    push_item(hbch_pkg::CMD_LOAD, 24'h030000, 24'h030000, 24'h030800, 24'h031000);
    push_item(CMD_UNUSED, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    push_item(hbch_pkg::CMD_FRAME, 0, 0, 0, 0);
    push_item(hbch_pkg::CMD_READ, 0, 0, 0, 0);
    push_item(hbch_pkg::CMD_READ, 0, 0, 0, 0);
    wait_idle();

    // capacity: one bond past the store, pairs below the first bin edge
    write_reg(hbch_pkg::CFG_BOX_W, 24'd4095);
    write_reg(hbch_pkg::CFG_BOX_H, 24'd0);
    write_reg(hbch_pkg::CFG_MIN_D, 24'h000800);
    write_reg(hbch_pkg::CFG_BIN_W, 24'hFFFFFF);
    for (int i = 0; i <= BOND_CAP; i++) push_random_bond(12'd4, 12'd4);
    push_item(hbch_pkg::CMD_FRAME, 0, 0, 0, 0);
    push_item(hbch_pkg::CMD_READ, 0, 0, 0, 0);
    wait_idle();

    for (int ph = 0; ph < 5; ph++) begin
      write_reg(hbch_pkg::CFG_BOX_W,
                pick_value(24'd0, 24'd4095, 24'($urandom_range(1, 64))));
      write_reg(hbch_pkg::CFG_BOX_H,
                pick_value(24'd1, 24'd4095, 24'($urandom_range(1, 64))));
      write_reg(hbch_pkg::CFG_MIN_D,
                pick_value(24'd0, 24'hFFFFFF, 24'($urandom_range(0, 24'h008000))));
      write_reg(hbch_pkg::CFG_BIN_W,
                pick_value(24'd0, 24'hFFFFFF, 24'($urandom_range(1, 24'h010000))));
      bw_now = box_w_reg;
      bh_now = box_h_reg;
      for (int f = 0; f < 3; f++) begin
        nb = $urandom_range(0, 9);
        for (int b = 0; b < nb; b++) begin
          push_random_bond(bw_now, bh_now);
          if ($urandom_range(0, 15) == 0)
            push_item(CMD_UNUSED, 24'($urandom), 24'($urandom), 0, 0);
        end
        push_item(hbch_pkg::CMD_FRAME, 24'($urandom), 24'($urandom), 24'($urandom),
                  24'($urandom));
        if (f == 2 || $urandom_range(0, 2) == 0) push_item(hbch_pkg::CMD_READ, 0, 0, 0, 0);
      end
      wait_idle();
    end

    if (mismatches == 0 && bins_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: hexatic_bond_correlation_histogram_core.f
rtl/hbch_pkg.sv
rtl/hbch_div.sv
rtl/hbch_isqrt.sv
rtl/hbch_cordic.sv
rtl/hexatic_bond_correlation_histogram_core.sv
test/tb.sv
